@@ rtl/gcic_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcic_pkg
// Shared widths and register indexes for the gilbert curve index unit.
// ----------------------------------------------------------------------------
package gcic_pkg;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned IdxBits   = 31;
  localparam int unsigned CfgBits   = 16;
  localparam int unsigned CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] RegWidth  = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegHeight = 1'b1;
endpackage
`default_nettype wire

@@ rtl/gcic_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcic_stream_if
// Valid/ready channel carrying one payload of parameter type.
// ----------------------------------------------------------------------------
interface gcic_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/gilbert_curve_index_to_coords_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gilbert_curve_index_to_coords_unit
// Flow: the index passes through the chain of division cells (one quotient
// bit each), loads the walk, runs a split and a pick state per split level of
// the gilbert walk (about log2(max(w,h)) levels) and ends with a final run
// that registers the result.
// Throughput: one transaction at a time; the next one is taken the cycle after
// the result is accepted, so latency plus output stall sets the rate.
// Reset: extents return to 1, pipeline and output empty.
// ----------------------------------------------------------------------------
module gilbert_curve_index_to_coords_unit #(
  parameter int unsigned COORD_BITS = gcic_pkg::CoordBits
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [gcic_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  wire logic [gcic_pkg::CfgBits-1:0]      cfg_data_i,
  gcic_stream_if.sink                            in_if,
  gcic_stream_if.source                          out_if
);
  localparam int unsigned IB = gcic_pkg::IdxBits;
  localparam int unsigned DB = 2 * COORD_BITS;
  localparam int unsigned RB = DB + 1;

  logic [COORD_BITS-1:0] width_q, height_q, cfg_v;
  logic busy_q, out_valid_q;
  logic [COORD_BITS-1:0] px_q, py_q;
  logic [IB-1:0] layer_q;
  logic [DB-1:0] area;

  assign cfg_v = (cfg_data_i[COORD_BITS-1:0] == '0) ? COORD_BITS'(1)
                                                     : cfg_data_i[COORD_BITS-1:0];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= COORD_BITS'(1);
      height_q <= COORD_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gcic_pkg::RegWidth:  width_q <= cfg_v;
        gcic_pkg::RegHeight: height_q <= cfg_v;
        default: ;
      endcase
    end
  end
  assign area = DB'(width_q) * DB'(height_q);

  // division chain
  logic            v_c [IB+1];
  logic [RB-1:0]   r_c [IB+1];
  logic [IB-1:0]   q_c [IB+1];
  logic [IB-1:0]   n_c [IB+1];
  logic in_fire;
  assign in_fire = in_if.valid && in_if.ready;
  assign in_if.ready = !busy_q;
  assign v_c[0] = in_fire;
  assign r_c[0] = '0;
  assign q_c[0] = '0;
  assign n_c[0] = in_if.data;

  for (genvar i = 0; i < IB; i++) begin : g_div
    gcic_div_cell #(.RemBits(RB), .DivBits(DB), .IdxBits(IB)) u_cell (
      .clk_i, .rst_ni, .en_i(1'b1),
      .valid_i(v_c[i]), .rem_i(r_c[i]), .quo_i(q_c[i]), .num_i(n_c[i]), .div_i(area),
      .valid_o(v_c[i+1]), .rem_o(r_c[i+1]), .quo_o(q_c[i+1]), .num_o(n_c[i+1])
    );
  end

  logic walk_done;
  logic [COORD_BITS-1:0] wx, wy;
  gcic_walk #(.CoordBits(COORD_BITS)) u_walk (
    .clk_i, .rst_ni,
    .start_i(v_c[IB]), .dst_i(r_c[IB][DB-1:0]),
    .w_i(width_q), .h_i(height_q),
    .done_o(walk_done), .x_o(wx), .y_o(wy)
  );

  always_ff @(posedge clk_i) begin
    if (v_c[IB]) layer_q <= q_c[IB];
    if (walk_done) begin
      px_q <= wx; py_q <= wy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) busy_q <= 1'b1;
      else if (out_valid_q && out_if.ready) busy_q <= 1'b0;
      if (walk_done) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data.pos_x = 16'(px_q);
  assign out_if.data.pos_y = 16'(py_q);
  assign out_if.data.layer = layer_q;
endmodule
`default_nettype wire

@@ rtl/gcic_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcic_div_cell
// One restoring-division cell: handles one quotient bit per cycle while en_i
// is high and passes the partial remainder to the next cell through a register.
// ----------------------------------------------------------------------------
module gcic_div_cell #(
  parameter int unsigned RemBits = 33,
  parameter int unsigned DivBits = 32,
  parameter int unsigned IdxBits = 31
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [RemBits-1:0] rem_i,
  input  wire logic [IdxBits-1:0] quo_i,
  input  wire logic [IdxBits-1:0] num_i,
  input  wire logic [DivBits-1:0] div_i,
  output logic                    valid_o,
  output logic [RemBits-1:0]      rem_o,
  output logic [IdxBits-1:0]      quo_o,
  output logic [IdxBits-1:0]      num_o
);
  logic [RemBits-1:0] shifted;
  logic [RemBits:0]   diff;
  logic               take;
  logic               valid_q;
  logic [RemBits-1:0] rem_q;
  logic [IdxBits-1:0] quo_q, num_q;

  always_comb begin
    shifted = {rem_i[RemBits-2:0], num_i[IdxBits-1]};
    diff = {1'b0, shifted} - {{(RemBits + 1 - DivBits){1'b0}}, div_i};
    take = !diff[RemBits];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= take ? diff[RemBits-1:0] : shifted;
      quo_q <= {quo_i[IdxBits-2:0], take};
      num_q <= {num_i[IdxBits-2:0], 1'b0};
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign num_o   = num_q;
endmodule
`default_nettype wire

@@ rtl/gcic_walk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcic_walk
// Iterative gilbert split walk: a split state and a pick state per level, with
// a registered multiply step between the split decision and the range compare.
// ----------------------------------------------------------------------------
module gcic_walk #(
  parameter int unsigned CoordBits = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [2*CoordBits-1:0] dst_i,
  input  wire logic [CoordBits-1:0]   w_i,
  input  wire logic [CoordBits-1:0]   h_i,
  output logic                        done_o,
  output logic [CoordBits-1:0]        x_o,
  output logic [CoordBits-1:0]        y_o
);
  localparam int unsigned SB = CoordBits + 2;
  localparam int unsigned AB = 2 * CoordBits + 2;
  localparam int unsigned StepBits = $clog2(8 * CoordBits + 17);
  localparam logic [StepBits-1:0] StepLimit = StepBits'(8 * CoordBits + 16);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSplit = 2'd1;
  localparam logic [1:0] StPick = 2'd2;

  logic [1:0] st_q, st_d;
  logic signed [SB-1:0] ax_q, ay_q, bx_q, by_q, x_q, y_q;
  logic signed [SB-1:0] ax_d, ay_d, bx_d, by_d, x_d, y_d;
  logic [AB-1:0] cur_q, cur_d, dst_q;
  logic [StepBits-1:0] n_q, n_d;
  // split decision held for the pick cycle
  logic long_q, long_d;
  logic signed [SB-1:0] ax2_q, ay2_q, bx2_q, by2_q, ax2_d, ay2_d, bx2_d, by2_d;
  logic [AB-1:0] p1_q, p2_q, p1_d, p2_d;

  function automatic logic signed [SB-1:0] sgn(input logic signed [SB-1:0] v);
    sgn = (v > 0) ? SB'(1) : ((v < 0) ? -SB'(1) : SB'(0));
  endfunction
  function automatic logic signed [SB-1:0] mag(input logic signed [SB-1:0] v);
    mag = v[SB-1] ? -v : v;
  endfunction

  logic signed [SB-1:0] w, h, dax, day, dbx, dby, hx, hy, hbx, hby, w2, h2, di;
  logic signed [SB-1:0] sbx, sby;
  logic [SB+1:0] w2x, h3x;
  logic signed [AB-1:0] m1, m2;

  always_comb begin
    st_d = st_q;
    ax_d = ax_q; ay_d = ay_q; bx_d = bx_q; by_d = by_q;
    x_d = x_q; y_d = y_q; cur_d = cur_q; n_d = n_q; long_d = long_q;
    ax2_d = ax2_q; ay2_d = ay2_q; bx2_d = bx2_q; by2_d = by2_q;
    p1_d = p1_q; p2_d = p2_q;
    w = mag(ax_q + ay_q);
    h = mag(bx_q + by_q);
    dax = sgn(ax_q); day = sgn(ay_q); dbx = sgn(bx_q); dby = sgn(by_q);
    di = SB'(dst_q - cur_q);
    hx = ax_q >>> 1; hy = ay_q >>> 1; hbx = bx_q >>> 1; hby = by_q >>> 1;
    w2 = mag(hx + hy);
    h2 = mag(hbx + hby);
    w2x = {2'b0, w} << 1;
    h3x = ({2'b0, h} << 1) + {2'b0, h};
    m1 = '0; m2 = '0;
    sbx = '0; sby = '0;
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          cur_d = '0; n_d = '0; x_d = '0; y_d = '0;
          if (w_i >= h_i) begin
            ax_d = SB'(w_i); ay_d = '0; bx_d = '0; by_d = SB'(h_i);
          end else begin
            ax_d = '0; ay_d = SB'(h_i); bx_d = SB'(w_i); by_d = '0;
          end
          st_d = StSplit;
        end
      end
      StSplit: begin
        if (n_q == StepLimit) begin
          st_d = StIdle;
        end else if (h == SB'(1)) begin
          x_d = x_q + dax * di; y_d = y_q + day * di; st_d = StIdle;
        end else if (w == SB'(1)) begin
          x_d = x_q + dbx * di; y_d = y_q + dby * di; st_d = StIdle;
        end else begin
          n_d = n_q + 1'b1;
          long_d = w2x > h3x;
          if (w2x > h3x) begin
            if (w2[0] && w > SB'(2)) begin
              hx = hx + dax; hy = hy + day;
            end
            m1 = AB'(hx + hy) * AB'(bx_q + by_q);
          end else begin
            if (h2[0] && h > SB'(2)) begin
              hbx = hbx + dbx; hby = hby + dby;
            end
            sbx = bx_q - hbx; sby = by_q - hby;
            m1 = AB'(hbx + hby) * AB'(hx + hy);
            m2 = AB'(ax_q + ay_q) * AB'(sbx + sby);
          end
          ax2_d = hx; ay2_d = hy; bx2_d = hbx; by2_d = hby;
          p1_d = m1[AB-1] ? AB'(-m1) : AB'(m1);
          p2_d = m2[AB-1] ? AB'(-m2) : AB'(m2);
          st_d = StPick;
        end
      end
      default: begin
        st_d = StSplit;
        if (long_q) begin
          if (dst_q < cur_q + p1_q) begin
            ax_d = ax2_q; ay_d = ay2_q;
          end else begin
            cur_d = cur_q + p1_q;
            x_d = x_q + ax2_q; y_d = y_q + ay2_q;
            ax_d = ax_q - ax2_q; ay_d = ay_q - ay2_q;
          end
        end else if (dst_q < cur_q + p1_q) begin
          ax_d = bx2_q; ay_d = by2_q; bx_d = ax2_q; by_d = ay2_q;
        end else if (dst_q < cur_q + p1_q + p2_q) begin
          cur_d = cur_q + p1_q;
          x_d = x_q + bx2_q; y_d = y_q + by2_q;
          bx_d = bx_q - bx2_q; by_d = by_q - by2_q;
        end else begin
          cur_d = cur_q + p1_q + p2_q;
          x_d = x_q + (ax_q - dax) + (bx2_q - dbx);
          y_d = y_q + (ay_q - day) + (by2_q - dby);
          ax_d = -bx2_q; ay_d = -by2_q;
          bx_d = -(ax_q - ax2_q); by_d = -(ay_q - ay2_q);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && start_i) begin
      dst_q <= AB'(dst_i);
    end
    ax_q <= ax_d; ay_q <= ay_d; bx_q <= bx_d; by_q <= by_d;
    x_q <= x_d; y_q <= y_d; cur_q <= cur_d; n_q <= n_d; long_q <= long_d;
    ax2_q <= ax2_d; ay2_q <= ay2_d; bx2_q <= bx2_d; by2_q <= by2_d;
    p1_q <= p1_d; p2_q <= p2_d;
  end

  assign done_o = (st_q == StSplit) && (st_d == StIdle);
  assign x_o = x_d[CoordBits-1:0];
  assign y_o = y_d[CoordBits-1:0];
endmodule
`default_nettype wire
